// ===== rtl/lrpw_pkg.sv =====
package lrpw_pkg;

  localparam int ADDR_W  = 22;
  localparam int COLOR_W = 24;
  localparam int CNT_W   = 2;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic MODE_8BPP  = 1'b0;
  localparam logic MODE_24BPP = 1'b1;

  localparam logic [CNT_W-1:0] BYTES_8BPP  = 2'd1;
  localparam logic [CNT_W-1:0] BYTES_24BPP = 2'd3;

  // word index of the mode register on the config port
  localparam logic REG_PIXEL_MODE = 1'b0;

  localparam logic [7:0] MASK_RED   = 8'he0;
  localparam logic [7:0] MASK_GREEN = 8'h1c;
  localparam logic [7:0] MASK_BLUE  = 8'h03;

  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

  function automatic logic [7:0] pack332(input logic [COLOR_W-1:0] c);
    logic [7:0] r, g, b;
    r = c[23:16] & MASK_RED;
    g = {c[15:11], 3'b000} >> 3 & MASK_GREEN;
    b = {6'b0, c[7:6]} & MASK_BLUE;
    return r | g | b;
  endfunction

endpackage

// ===== rtl/lrpw_cmd_if.sv =====
interface lrpw_cmd_if #(
  parameter int COORD_BITS = 10
);
  logic                           valid;
  logic                           ready;
  logic                           cmd;
  logic [COORD_BITS-1:0]          start_x;
  logic [COORD_BITS-1:0]          start_y;
  logic [COORD_BITS-1:0]          end_x;
  logic [COORD_BITS-1:0]          end_y;
  logic [lrpw_pkg::COLOR_W-1:0]   draw_color;

  modport source (
    output valid, cmd, start_x, start_y, end_x, end_y, draw_color,
    input  ready
  );
  modport sink (
    input  valid, cmd, start_x, start_y, end_x, end_y, draw_color,
    output ready
  );
endinterface

// ===== rtl/lrpw_pix_if.sv =====
interface lrpw_pix_if;
  logic                           valid;
  logic                           ready;
  logic [lrpw_pkg::ADDR_W-1:0]    byte_address;
  logic [lrpw_pkg::COLOR_W-1:0]   pixel_bytes;
  logic [lrpw_pkg::CNT_W-1:0]     byte_count;
  logic                           last;

  modport source (
    output valid, byte_address, pixel_bytes, byte_count, last,
    input  ready
  );
  modport sink (
    input  valid, byte_address, pixel_bytes, byte_count, last,
    output ready
  );
endinterface

// ===== rtl/lrpw_stepper.sv =====
module lrpw_stepper #(
  parameter int COORD_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  lrpw_cmd_if.sink                      cmd_chan,
  output lrpw_pkg::stage_ctl_t          pix_ctl,
  output logic [COORD_BITS-1:0]         pix_x,
  output logic [COORD_BITS-1:0]         pix_y,
  output logic [lrpw_pkg::COLOR_W-1:0]  pix_color
);

  localparam int ERR_W = COORD_BITS + 3;

  logic [COORD_BITS-1:0]        cur_x, cur_y, goal_x, goal_y;
  logic signed [COORD_BITS:0]   abs_dx, neg_abs_dy;
  logic signed [ERR_W-1:0]      err_term;
  logic                         dir_x_neg, dir_y_neg;
  logic [lrpw_pkg::COLOR_W-1:0] held_color;
  logic                         busy;

  logic [COORD_BITS-1:0]        cur_x_next, cur_y_next, goal_x_next, goal_y_next;
  logic signed [COORD_BITS:0]   abs_dx_next, neg_abs_dy_next;
  logic signed [ERR_W-1:0]      err_term_next;
  logic                         dir_x_neg_next, dir_y_neg_next;
  logic [lrpw_pkg::COLOR_W-1:0] held_color_next;

  logic                         is_start, emits, take, at_end;
  logic [COORD_BITS-1:0]        diff_x, diff_y;
  logic signed [ERR_W:0]        twice;
  logic                         move_x, move_y;

  assign cmd_chan.ready = advance;
  assign is_start = (cmd_chan.cmd == lrpw_pkg::CMD_START);
  assign emits    = cmd_chan.valid && (is_start || busy);
  assign take     = advance && emits;

  assign diff_x = (cmd_chan.end_x >= cmd_chan.start_x) ? cmd_chan.end_x - cmd_chan.start_x
                                                       : cmd_chan.start_x - cmd_chan.end_x;
  assign diff_y = (cmd_chan.end_y >= cmd_chan.start_y) ? cmd_chan.end_y - cmd_chan.start_y
                                                       : cmd_chan.start_y - cmd_chan.end_y;

  assign twice  = {err_term, 1'b0};
  assign move_x = (twice >= (ERR_W+1)'(neg_abs_dy));
  assign move_y = (twice <= (ERR_W+1)'(abs_dx));

  always_comb begin
    cur_x_next      = cur_x;
    cur_y_next      = cur_y;
    goal_x_next     = goal_x;
    goal_y_next     = goal_y;
    abs_dx_next     = abs_dx;
    neg_abs_dy_next = neg_abs_dy;
    err_term_next   = err_term;
    dir_x_neg_next  = dir_x_neg;
    dir_y_neg_next  = dir_y_neg;
    held_color_next = held_color;
    if (is_start) begin
      cur_x_next      = cmd_chan.start_x;
      cur_y_next      = cmd_chan.start_y;
      goal_x_next     = cmd_chan.end_x;
      goal_y_next     = cmd_chan.end_y;
      held_color_next = cmd_chan.draw_color;
      dir_x_neg_next  = !(cmd_chan.start_x < cmd_chan.end_x);
      dir_y_neg_next  = !(cmd_chan.start_y < cmd_chan.end_y);
      abs_dx_next     = $signed({1'b0, diff_x});
      neg_abs_dy_next = -$signed({1'b0, diff_y});
      err_term_next   = ERR_W'(abs_dx_next) + ERR_W'(neg_abs_dy_next);
    end else begin
      err_term_next = err_term + (move_x ? ERR_W'(neg_abs_dy) : '0)
                               + (move_y ? ERR_W'(abs_dx) : '0);
      if (move_x) begin
        cur_x_next = dir_x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
      end
      if (move_y) begin
        cur_y_next = dir_y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
      end
    end
  end

  assign at_end = (cur_x_next == goal_x_next) && (cur_y_next == goal_y_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x         <= '0;
      cur_y         <= '0;
      goal_x        <= '0;
      goal_y        <= '0;
      abs_dx        <= '0;
      neg_abs_dy    <= '0;
      err_term      <= '0;
      dir_x_neg     <= 1'b0;
      dir_y_neg     <= 1'b0;
      held_color    <= '0;
      busy          <= 1'b0;
      pix_ctl.valid <= 1'b0;
      pix_ctl.last  <= 1'b0;
    end else if (advance) begin
      pix_ctl.valid <= emits;
      if (take) begin
        cur_x        <= cur_x_next;
        cur_y        <= cur_y_next;
        goal_x       <= goal_x_next;
        goal_y       <= goal_y_next;
        abs_dx       <= abs_dx_next;
        neg_abs_dy   <= neg_abs_dy_next;
        err_term     <= err_term_next;
        dir_x_neg    <= dir_x_neg_next;
        dir_y_neg    <= dir_y_neg_next;
        held_color   <= held_color_next;
        busy         <= !at_end;
        pix_ctl.last <= at_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pix_x     <= cur_x_next;
      pix_y     <= cur_y_next;
      pix_color <= held_color_next;
    end
  end

  a_idle_step_silent: assert property (@(posedge clk) disable iff (rst)
    advance && cmd_chan.valid && cmd_chan.cmd == lrpw_pkg::CMD_STEP && !busy
    |=> !pix_ctl.valid)
    else $error("step while idle produced a pixel");

  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    pix_ctl.valid && pix_ctl.last |-> !busy)
    else $error("line still busy after its last pixel");

  a_busy_not_at_goal: assert property (@(posedge clk)
    busy |-> !(cur_x == goal_x && cur_y == goal_y))
    else $error("busy with the current pixel at the end point");

endmodule

// ===== rtl/line_rasterizer_pixel_writer.sv =====
// Bresenham line drawer with framebuffer pixel writer. A start item latches both
// endpoints and the colour and yields the first pixel write; each step item
// yields the next pixel, with last set on the end point; a step while no line is
// active yields nothing. Items are taken one per clock while the output is not
// stalled; a pixel write leaves through a stepper register and then an address
// register. The error/position update in the stepper sets that rate.
// When the output is stalled the whole pipe holds and the input is not ready.
// pixel_mode (register 0, byte address 0) selects 8bpp RGB332 or 24bpp writes
// and is to be written only while no line is being drawn.
module line_rasterizer_pixel_writer #(
  parameter int STRIDE_8BPP  = 640,
  parameter int STRIDE_24BPP = 1920,
  parameter int COORD_BITS   = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  lrpw_cmd_if.sink                       cmd_chan,
  lrpw_pix_if.source                     pix_chan,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lrpw_pkg::PADDR_W-1:0]   paddr,
  input  logic [lrpw_pkg::PDATA_W-1:0]   pwdata,
  output logic [lrpw_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  localparam int STRIDE_W = $clog2(STRIDE_24BPP + 1);
  localparam int SUM_W    = COORD_BITS + STRIDE_W + 1;

  logic                          pixel_mode;
  logic                          advance;
  lrpw_pkg::stage_ctl_t          pix_ctl;
  logic [COORD_BITS-1:0]         pix_x, pix_y;
  logic [lrpw_pkg::COLOR_W-1:0]  pix_color;
  logic [STRIDE_W-1:0]           stride;
  logic [SUM_W-1:0]              row_base, col_off;
  logic                          reg_sel;

  // config port
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == lrpw_pkg::REG_PIXEL_MODE);
  assign prdata  = reg_sel ? lrpw_pkg::PDATA_W'(pixel_mode) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_mode <= lrpw_pkg::MODE_8BPP;
    end else if (psel && penable && pwrite && reg_sel) begin
      pixel_mode <= pwdata[0];
    end
  end

  assign advance = !pix_chan.valid || pix_chan.ready;

  lrpw_stepper #(
    .COORD_BITS (COORD_BITS)
  ) u_stepper (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .cmd_chan  (cmd_chan),
    .pix_ctl   (pix_ctl),
    .pix_x     (pix_x),
    .pix_y     (pix_y),
    .pix_color (pix_color)
  );

  // one multiplier shared by both modes
  assign stride   = (pixel_mode == lrpw_pkg::MODE_24BPP) ? STRIDE_W'(STRIDE_24BPP)
                                                         : STRIDE_W'(STRIDE_8BPP);
  assign row_base = SUM_W'(pix_y * stride);
  assign col_off  = (pixel_mode == lrpw_pkg::MODE_24BPP)
                    ? SUM_W'(pix_x) + SUM_W'({pix_x, 1'b0})
                    : SUM_W'(pix_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_chan.valid <= 1'b0;
    end else if (advance) begin
      pix_chan.valid <= pix_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && pix_ctl.valid) begin
      pix_chan.byte_address <= lrpw_pkg::ADDR_W'(row_base + col_off);
      pix_chan.last         <= pix_ctl.last;
      if (pixel_mode == lrpw_pkg::MODE_24BPP) begin
        pix_chan.pixel_bytes <= pix_color;
        pix_chan.byte_count  <= lrpw_pkg::BYTES_24BPP;
      end else begin
        pix_chan.pixel_bytes <= lrpw_pkg::COLOR_W'(lrpw_pkg::pack332(pix_color));
        pix_chan.byte_count  <= lrpw_pkg::BYTES_8BPP;
      end
    end
  end

  a_stage_held: assert property (@(posedge clk) disable iff (rst)
    pix_ctl.valid && !advance |=> pix_ctl.valid)
    else $error("stepper item dropped while output stalled");

  a_count_legal: assert property (@(posedge clk) disable iff (rst)
    pix_chan.valid |-> pix_chan.byte_count == lrpw_pkg::BYTES_8BPP ||
                       pix_chan.byte_count == lrpw_pkg::BYTES_24BPP)
    else $error("illegal byte count");

  a_8bpp_upper_zero: assert property (@(posedge clk) disable iff (rst)
    pix_chan.valid && pix_chan.byte_count == lrpw_pkg::BYTES_8BPP
    |-> pix_chan.pixel_bytes[lrpw_pkg::COLOR_W-1:8] == '0)
    else $error("8bpp write carries upper bytes");

endmodule

// ===== tb/line_rasterizer_pixel_writer_test.sv =====
`timescale 1ns / 100ps

module line_rasterizer_pixel_writer_test;

  localparam int COORD_W       = 10;
  localparam int LINE_PITCH_8  = 640;
  localparam int LINE_PITCH_24 = 1920;
  localparam int LATENCY_PAD   = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int WATCHDOG      = 3000;
  localparam int PHASE_PIXELS  = 375;
  localparam int NUM_PHASES    = 4;

  localparam logic [lrpw_pkg::PADDR_W-1:0] MODE_ADDR =
    lrpw_pkg::PADDR_W'(4 * int'(lrpw_pkg::REG_PIXEL_MODE));
  // first word past the mode register, writes there are dropped
  localparam logic [lrpw_pkg::PADDR_W-1:0] SPARE_ADDR =
    lrpw_pkg::PADDR_W'(4 * (int'(lrpw_pkg::REG_PIXEL_MODE) + 1));

  localparam int   SRC_IDLE [NUM_PHASES]   = '{0, 61, 0, 29};
  localparam int   SINK_STALL [NUM_PHASES] = '{0, 0, 61, 29};
  localparam logic PHASE_MODE [NUM_PHASES] = '{lrpw_pkg::MODE_8BPP, lrpw_pkg::MODE_24BPP,
                                               lrpw_pkg::MODE_8BPP, lrpw_pkg::MODE_24BPP};

  typedef struct packed {
    logic                         cmd;
    logic [COORD_W-1:0]           sx;
    logic [COORD_W-1:0]           sy;
    logic [COORD_W-1:0]           ex;
    logic [COORD_W-1:0]           ey;
    logic [lrpw_pkg::COLOR_W-1:0] color;
  } cmd_item_t;

  typedef struct packed {
    logic [lrpw_pkg::ADDR_W-1:0]  addr;
    logic [lrpw_pkg::COLOR_W-1:0] data;
    logic [lrpw_pkg::CNT_W-1:0]   count;
    logic                         last;
  } pix_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_FIXED, ROW_SILENT} row_kind_t;

  typedef struct {
    row_kind_t kind;
    logic      mode;
    cmd_item_t item;
    pix_t      want;
  } row_t;

  logic                          clk;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [lrpw_pkg::PADDR_W-1:0]  paddr;
  logic [lrpw_pkg::PDATA_W-1:0]  pwdata;
  logic [lrpw_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;

  lrpw_cmd_if #(.COORD_BITS(COORD_W)) cmd_chan ();
  lrpw_pix_if pix_chan ();

  line_rasterizer_pixel_writer #(
    .STRIDE_8BPP  (LINE_PITCH_8),
    .STRIDE_24BPP (LINE_PITCH_24),
    .COORD_BITS   (COORD_W)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_chan (cmd_chan),
    .pix_chan (pix_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // line tracer state, mirrors the block
  logic                          line_mode;
  logic [COORD_W-1:0]            trace_x, trace_y, end_col, end_row;
  logic signed [10:0]            run_x, neg_rise;
  logic signed [12:0]            err_acc;
  logic                          x_back, y_back;
  logic [lrpw_pkg::COLOR_W-1:0]  line_color;
  logic                          drawing;

  pix_t pending_writes[$];
  row_t steer[$];
  int   mismatches;
  int   pixels_drawn;
  int   src_idle_pct;
  int   sink_stall_pct;
  int   hold_reqs;
  int   hold_seen;
  int   hold_left;
  int   quiet;

  task automatic flag(input string msg);
    $display("t=%0t %s", $time, msg);
    mismatches++;
  endtask

  task automatic trace_item(input cmd_item_t it, output bit emits, output pix_t px);
    logic signed [13:0] twice;
    logic [COORD_W-1:0] span_x, span_y;
    int unsigned        offs;
    emits = 1'b0;
    px    = '0;
    if (it.cmd == lrpw_pkg::CMD_START) begin
      trace_x    = it.sx;
      trace_y    = it.sy;
      end_col    = it.ex;
      end_row    = it.ey;
      line_color = it.color;
      x_back     = !(it.sx < it.ex);
      y_back     = !(it.sy < it.ey);
      span_x     = (it.ex >= it.sx) ? it.ex - it.sx : it.sx - it.ex;
      span_y     = (it.ey >= it.sy) ? it.ey - it.sy : it.sy - it.ey;
      run_x      = {1'b0, span_x};
      neg_rise   = -$signed({1'b0, span_y});
      err_acc    = run_x + neg_rise;
    end else if (!drawing) begin
      return;
    end else begin
      twice = err_acc * 14'sd2;
      if (twice >= neg_rise) begin
        err_acc = err_acc + neg_rise;
        trace_x = x_back ? trace_x - 1'b1 : trace_x + 1'b1;
      end
      if (twice <= run_x) begin
        err_acc = err_acc + run_x;
        trace_y = y_back ? trace_y - 1'b1 : trace_y + 1'b1;
      end
    end
    emits = 1'b1;
    if (line_mode == lrpw_pkg::MODE_8BPP) begin
      offs     = trace_y * LINE_PITCH_8 + trace_x;
      // rgb332: top bits of each channel
      px.data  = {16'h0, line_color[23:21], line_color[15:13], line_color[7:6]};
      px.count = lrpw_pkg::BYTES_8BPP;
    end else begin
      offs     = trace_y * LINE_PITCH_24 + 3 * trace_x;
      px.data  = line_color;
      px.count = lrpw_pkg::BYTES_24BPP;
    end
    px.addr = offs[lrpw_pkg::ADDR_W-1:0];
    px.last = (trace_x == end_col) && (trace_y == end_row);
    drawing = !px.last;
  endtask

  task automatic push_cmd(input cmd_item_t it, input row_kind_t kind, input pix_t want);
    pix_t px;
    bit   emits;
    if ($urandom_range(99) < src_idle_pct) begin
      cmd_chan.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    cmd_chan.valid      <= 1'b1;
    cmd_chan.cmd        <= it.cmd;
    cmd_chan.start_x    <= it.sx;
    cmd_chan.start_y    <= it.sy;
    cmd_chan.end_x      <= it.ex;
    cmd_chan.end_y      <= it.ey;
    cmd_chan.draw_color <= it.color;
    do @(posedge clk); while (!cmd_chan.ready);
    trace_item(it, emits, px);
    if (emits)
      pixels_drawn++;
    case (kind)
      ROW_FIXED: pending_writes.push_back(want);
      ROW_SILENT: ;
      default: if (emits) pending_writes.push_back(px);
    endcase
  endtask

  task automatic settle();
    cmd_chan.valid <= 1'b0;
    while (pending_writes.size() != 0)
      @(posedge clk);
    // a step with no result may still be in the pipe
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lrpw_pkg::PADDR_W-1:0] addr,
                           input logic [lrpw_pkg::PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == MODE_ADDR)
      line_mode = data[0];
  endtask

  function automatic cmd_item_t any_item();
    cmd_item_t it;
    it.cmd   = 1'($urandom);
    it.sx    = COORD_W'($urandom);
    it.sy    = COORD_W'($urandom);
    it.ex    = COORD_W'($urandom);
    it.ey    = COORD_W'($urandom);
    it.color = lrpw_pkg::COLOR_W'($urandom);
    return it;
  endfunction

  function automatic logic [COORD_W-1:0] near(input logic [COORD_W-1:0] c);
    int d, v;
    d = int'($urandom_range(30)) - 15;
    v = int'(c) + d;
    if (v < 0 || v > 1023)
      v = int'(c) - d;
    return COORD_W'(v);
  endfunction

  function automatic logic [COORD_W-1:0] rim();
    case ($urandom_range(2))
      0: return '0;
      1: return '1;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic row_t row(row_kind_t kind, logic mode, logic cmd,
                               int sx, int sy, int ex, int ey, int color,
                               int addr = 0, int data = 0, int count = 0, bit last = 0);
    row_t r;
    r.kind       = kind;
    r.mode       = mode;
    r.item.cmd   = cmd;
    r.item.sx    = COORD_W'(sx);
    r.item.sy    = COORD_W'(sy);
    r.item.ex    = COORD_W'(ex);
    r.item.ey    = COORD_W'(ey);
    r.item.color = lrpw_pkg::COLOR_W'(color);
    r.want.addr  = lrpw_pkg::ADDR_W'(addr);
    r.want.data  = lrpw_pkg::COLOR_W'(data);
    r.want.count = lrpw_pkg::CNT_W'(count);
    r.want.last  = last;
    return r;
  endfunction

  task automatic push_step();
    cmd_item_t it;
    it     = any_item();
    it.cmd = lrpw_pkg::CMD_STEP;
    push_cmd(it, ROW_PREDICT, '0);
  endtask

  task automatic random_line();
    cmd_item_t it;
    int        shape, steps_left;
    shape  = $urandom_range(99);
    it     = any_item();
    it.cmd = lrpw_pkg::CMD_START;
    if (shape < 75) begin
      it.ex      = near(it.sx);
      it.ey      = near(it.sy);
      steps_left = ($urandom_range(9) == 0) ? $urandom_range(6) : 4096;
    end else if (shape < 88) begin
      // far endpoints, cut short by the next start
      steps_left = $urandom_range(24);
    end else begin
      it.sx      = rim();
      it.sy      = rim();
      it.ex      = rim();
      it.ey      = rim();
      steps_left = $urandom_range(24);
    end
    push_cmd(it, ROW_PREDICT, '0);
    while (drawing && steps_left != 0) begin
      push_step();
      steps_left--;
    end
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 2)) push_step();
  endtask

  // output side: check each item, then pick ready for the next cycle
  always @(posedge clk) begin : pixel_sink
    pix_t got, want;
    if (!rst && pix_chan.valid && pix_chan.ready) begin
      got = {pix_chan.byte_address, pix_chan.pixel_bytes, pix_chan.byte_count, pix_chan.last};
      if (pending_writes.size() == 0) begin
        flag($sformatf("unexpected pixel write addr %0h", got.addr));
      end else begin
        want = pending_writes.pop_front();
        if (got.addr !== want.addr)
          flag($sformatf("byte_address %0h, expected %0h", got.addr, want.addr));
        if (got.data !== want.data)
          flag($sformatf("pixel_bytes %0h, expected %0h", got.data, want.data));
        if (got.count !== want.count)
          flag($sformatf("byte_count %0d, expected %0d", got.count, want.count));
        if (got.last !== want.last)
          flag($sformatf("last %0b, expected %0b", got.last, want.last));
      end
    end
    if (hold_reqs != hold_seen) begin
      hold_seen      <= hold_reqs;
      hold_left      <= HOLD_CYCLES;
      pix_chan.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left      <= hold_left - 1;
      pix_chan.ready <= 1'b0;
    end else begin
      pix_chan.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_chan.valid && cmd_chan.ready) || (pix_chan.valid && pix_chan.ready)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG) begin
      $display("line_rasterizer_pixel_writer_test: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    cmd_item_t it;
    int        base;
    bit        held;
    rst                 <= 1'b1;
    cmd_chan.valid      <= 1'b0;
    cmd_chan.cmd        <= lrpw_pkg::CMD_START;
    cmd_chan.start_x    <= '0;
    cmd_chan.start_y    <= '0;
    cmd_chan.end_x      <= '0;
    cmd_chan.end_y      <= '0;
    cmd_chan.draw_color <= '0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    line_mode      = lrpw_pkg::MODE_8BPP;
    trace_x        = '0;
    trace_y        = '0;
    end_col        = '0;
    end_row        = '0;
    run_x          = '0;
    neg_rise       = '0;
    err_acc        = '0;
    x_back         = 1'b0;
    y_back         = 1'b0;
    line_color     = '0;
    drawing        = 1'b0;
    pixels_drawn   = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_reqs      = 0;
    held           = 1'b0;

    steer = '{
      // step with no line active, right after reset
      row(ROW_SILENT,  lrpw_pkg::MODE_8BPP,  lrpw_pkg::CMD_STEP,  0, 0, 0, 0, 0),
      row(ROW_FIXED,   lrpw_pkg::MODE_8BPP,  lrpw_pkg::CMD_START, 0, 0, 0, 0, 'hffffff,
          0, 'hff, lrpw_pkg::BYTES_8BPP, 1),
      row(ROW_SILENT,  lrpw_pkg::MODE_8BPP,  lrpw_pkg::CMD_STEP,  5, 5, 9, 9, 'h123456),
      row(ROW_FIXED,   lrpw_pkg::MODE_8BPP,  lrpw_pkg::CMD_START, 1023, 1023, 1023, 1023, 0,
          655743, 0, lrpw_pkg::BYTES_8BPP, 1),
      row(ROW_FIXED,   lrpw_pkg::MODE_8BPP,  lrpw_pkg::CMD_START, 1, 1, 1, 1, 'ha55ac3,
          641, 'hab, lrpw_pkg::BYTES_8BPP, 1),
      row(ROW_PREDICT, lrpw_pkg::MODE_8BPP,  lrpw_pkg::CMD_START, 0, 0, 3, 1, 'h123456),
      row(ROW_PREDICT, lrpw_pkg::MODE_8BPP,  lrpw_pkg::CMD_STEP,  0, 0, 0, 0, 0),
      row(ROW_PREDICT, lrpw_pkg::MODE_8BPP,  lrpw_pkg::CMD_STEP,  0, 0, 0, 0, 0),
      row(ROW_PREDICT, lrpw_pkg::MODE_8BPP,  lrpw_pkg::CMD_STEP,  0, 0, 0, 0, 0),
      // past the end point
      row(ROW_SILENT,  lrpw_pkg::MODE_8BPP,  lrpw_pkg::CMD_STEP,  1023, 1023, 1023, 1023,
          'hffffff),
      row(ROW_PREDICT, lrpw_pkg::MODE_8BPP,  lrpw_pkg::CMD_START, 10, 10, 8, 15, 'ha5a5a5),
      row(ROW_PREDICT, lrpw_pkg::MODE_8BPP,  lrpw_pkg::CMD_STEP,  0, 0, 0, 0, 0),
      row(ROW_PREDICT, lrpw_pkg::MODE_8BPP,  lrpw_pkg::CMD_STEP,  0, 0, 0, 0, 0),
      // new start abandons the steep line
      row(ROW_PREDICT, lrpw_pkg::MODE_8BPP,  lrpw_pkg::CMD_START, 1023, 0, 1020, 0, 'h00ff00),
      row(ROW_PREDICT, lrpw_pkg::MODE_8BPP,  lrpw_pkg::CMD_STEP,  0, 0, 0, 0, 0),
      row(ROW_PREDICT, lrpw_pkg::MODE_8BPP,  lrpw_pkg::CMD_STEP,  0, 0, 0, 0, 0),
      row(ROW_PREDICT, lrpw_pkg::MODE_8BPP,  lrpw_pkg::CMD_STEP,  0, 0, 0, 0, 0),
      row(ROW_FIXED,   lrpw_pkg::MODE_24BPP, lrpw_pkg::CMD_START, 1023, 1023, 1023, 1023,
          'habcdef, 1967229, 'habcdef, lrpw_pkg::BYTES_24BPP, 1),
      row(ROW_FIXED,   lrpw_pkg::MODE_24BPP, lrpw_pkg::CMD_START, 0, 0, 0, 0, 'hffffff,
          0, 'hffffff, lrpw_pkg::BYTES_24BPP, 1),
      row(ROW_PREDICT, lrpw_pkg::MODE_24BPP, lrpw_pkg::CMD_START, 5, 0, 5, 2, 'h0f1e2d),
      row(ROW_PREDICT, lrpw_pkg::MODE_24BPP, lrpw_pkg::CMD_STEP,  0, 0, 0, 0, 0),
      row(ROW_PREDICT, lrpw_pkg::MODE_24BPP, lrpw_pkg::CMD_STEP,  0, 0, 0, 0, 0),
      row(ROW_PREDICT, lrpw_pkg::MODE_24BPP, lrpw_pkg::CMD_START, 2, 7, 0, 0, 'h808080),
      row(ROW_PREDICT, lrpw_pkg::MODE_24BPP, lrpw_pkg::CMD_STEP,  0, 0, 0, 0, 0)
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (steer[i]) begin
      if (steer[i].mode != line_mode) begin
        settle();
        write_reg(MODE_ADDR, {31'h0, steer[i].mode});
      end
      push_cmd(steer[i].item, steer[i].kind, steer[i].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (drawing) begin
        // a zero-length line ends the one in flight before the mode changes
        it     = any_item();
        it.cmd = lrpw_pkg::CMD_START;
        it.ex  = it.sx;
        it.ey  = it.sy;
        push_cmd(it, ROW_PREDICT, '0);
      end
      settle();
      write_reg(SPARE_ADDR, {31'($urandom), ~PHASE_MODE[p]});
      write_reg(MODE_ADDR, {31'($urandom), PHASE_MODE[p]});
      src_idle_pct   = SRC_IDLE[p];
      sink_stall_pct = SINK_STALL[p];
      base           = pixels_drawn;
      while (pixels_drawn - base < PHASE_PIXELS) begin
        if (SRC_IDLE[p] == 0 && SINK_STALL[p] == 0 && !held && pixels_drawn - base >= 100) begin
          hold_reqs <= hold_reqs + 1;
          held = 1'b1;
        end
        if ($urandom_range(19) == 0)
          push_step();
        else
          random_line();
      end
    end

    settle();
    if (mismatches == 0 && pending_writes.size() == 0)
      $display("line_rasterizer_pixel_writer_test: PASS");
    else
      $display("line_rasterizer_pixel_writer_test: FAIL");
    $finish;
  end

endmodule

// ===== line_rasterizer_pixel_writer.f =====
rtl/lrpw_pkg.sv
rtl/lrpw_cmd_if.sv
rtl/lrpw_pix_if.sv
rtl/lrpw_stepper.sv
rtl/line_rasterizer_pixel_writer.sv
tb/line_rasterizer_pixel_writer_test.sv
